// ----- rtl/rmth_pkg.sv -----
// Package with shared types, constants and state codes for the running median block.
`timescale 1ns / 1ps
package rmth_pkg;
  localparam int MAX_COUNT_DEF  = 1024;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 32;
  localparam int COUNT_W  = 11;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                start_new;
  } in_beat_t;

  typedef struct packed {
    logic [MEDIAN_W-1:0] median;
    logic [COUNT_W-1:0]  count;
    logic                full_drop;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP,
    ST_UP_CMP,
    ST_TOP_RD,
    ST_TOP_CMP,
    ST_DN_RD,
    ST_DN_CMP,
    ST_FIN_RD,
    ST_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic accept;     // latch input beat, clear on start, choose heap
    logic up_read;    // read parent of the hole
    logic up_move;    // move parent down into the hole
    logic up_place;   // write sample into the hole and grow the heap
    logic top_swap;   // take both tops as the values to sift down
    logic dn_read;    // read both children of the hole
    logic dn_move;    // move the chosen child up into the hole
    logic dn_place;   // write the sifted value into the hole
    logic dn_switch;  // go on with the upper heap
    logic finish;     // load the result register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic drop;       // sample is dropped
    logic at_root;    // hole is at the root
    logic up_above;   // sample ranks above its parent
    logic need_swap;  // tops out of order
    logic leaf;       // hole has no children
    logic dn_above;   // chosen child ranks above the sifted value
    logic on_upper;   // heap under work is the upper one
  } stat_t;
endpackage

// ----- rtl/rmth_ctrl.sv -----
// Controller state machine sequencing insertion, top exchange and sift-down.
`timescale 1ns / 1ps
module rmth_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rmth_pkg::cmd_t    cmd,
  input  rmth_pkg::stat_t   stat
);
  rmth_pkg::state_t state, state_next;
  logic             out_pend, out_pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rmth_pkg::ST_IDLE;
      out_pend <= 1'b0;
    end else begin
      state    <= state_next;
      out_pend <= out_pend_next;
    end
  end

  // Result register frees once taken; a new item may start while it waits.
  always_comb begin
    out_pend_next = out_pend;
    if (out_pend && out_ready) out_pend_next = 1'b0;
    if (cmd.finish) out_pend_next = 1'b1;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rmth_pkg::ST_IDLE:    if (in_valid) state_next = rmth_pkg::ST_UP;
      rmth_pkg::ST_UP:      begin
        if (stat.drop) state_next = rmth_pkg::ST_FIN_RD;
        else if (stat.at_root) state_next = rmth_pkg::ST_TOP_RD;
        else state_next = rmth_pkg::ST_UP_CMP;
      end
      rmth_pkg::ST_UP_CMP:  state_next = stat.up_above ? rmth_pkg::ST_UP
                                                       : rmth_pkg::ST_TOP_RD;
      rmth_pkg::ST_TOP_RD:  state_next = rmth_pkg::ST_TOP_CMP;
      rmth_pkg::ST_TOP_CMP: state_next = stat.need_swap ? rmth_pkg::ST_DN_RD
                                                        : rmth_pkg::ST_FIN_RD;
      rmth_pkg::ST_DN_RD:   begin
        if (!stat.leaf) state_next = rmth_pkg::ST_DN_CMP;
        else if (stat.on_upper) state_next = rmth_pkg::ST_FIN_RD;
        else state_next = rmth_pkg::ST_DN_RD;
      end
      rmth_pkg::ST_DN_CMP:  begin
        if (stat.dn_above) state_next = rmth_pkg::ST_DN_RD;
        else if (stat.on_upper) state_next = rmth_pkg::ST_FIN_RD;
        else state_next = rmth_pkg::ST_DN_RD;
      end
      rmth_pkg::ST_FIN_RD:  state_next = rmth_pkg::ST_DONE;
      rmth_pkg::ST_DONE:    if (!out_pend || out_ready) state_next = rmth_pkg::ST_IDLE;
      default:              state_next = rmth_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = out_pend;
    unique case (state)
      rmth_pkg::ST_IDLE:    begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      rmth_pkg::ST_UP:      begin
        cmd.up_place = !stat.drop && stat.at_root;
        cmd.up_read  = !stat.drop && !stat.at_root;
      end
      rmth_pkg::ST_UP_CMP:  begin
        cmd.up_move  = stat.up_above;
        cmd.up_place = !stat.up_above;
      end
      rmth_pkg::ST_TOP_RD:  cmd = '0;
      rmth_pkg::ST_TOP_CMP: cmd.top_swap = stat.need_swap;
      rmth_pkg::ST_DN_RD:   begin
        cmd.dn_read   = !stat.leaf;
        cmd.dn_place  = stat.leaf;
        cmd.dn_switch = stat.leaf && !stat.on_upper;
      end
      rmth_pkg::ST_DN_CMP:  begin
        cmd.dn_move   = stat.dn_above;
        cmd.dn_place  = !stat.dn_above;
        cmd.dn_switch = !stat.dn_above && !stat.on_upper;
      end
      rmth_pkg::ST_FIN_RD:  cmd = '0;
      rmth_pkg::ST_DONE:    cmd.finish = !out_pend || out_ready;
      default:              cmd = '0;
    endcase
  end
endmodule

// ----- rtl/rmth_dp.sv -----
// Datapath with both heap memories, sizes, positions and compare logic.
`timescale 1ns / 1ps
module rmth_dp #(
  parameter int MAX_COUNT  = rmth_pkg::MAX_COUNT_DEF,
  parameter int DATA_WIDTH = rmth_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rmth_pkg::in_beat_t  in_beat,
  output rmth_pkg::out_beat_t out_beat,
  input  rmth_pkg::cmd_t      cmd,
  output rmth_pkg::stat_t     stat
);
  localparam int LO_D = (MAX_COUNT + 1) / 2;
  localparam int UP_D = MAX_COUNT / 2;
  localparam int LIW  = (LO_D > 1) ? $clog2(LO_D) : 1;
  localparam int UIW  = (UP_D > 1) ? $clog2(UP_D) : 1;
  localparam int SW   = $clog2(LO_D + 1);
  localparam int PW   = $clog2(2 * LO_D + 1);
  localparam int CW   = $clog2(MAX_COUNT + 1);

  logic [DATA_WIDTH-1:0] lo_mem [LO_D];
  logic [DATA_WIDTH-1:0] up_mem [UP_D];
  logic [DATA_WIDTH-1:0] lo_rd0, lo_rd1, up_rd0, up_rd1;

  logic [SW-1:0]         lo_size, up_size, lo_eff, up_eff, cur_size;
  logic [CW-1:0]         total_eff, total;
  logic                  sel_up;      // heap under work is the upper one
  logic                  drop, drop_next;
  logic [PW-1:0]         pos;         // position of the hole
  logic [PW-1:0]         parent, left, right, pick_a, ra0, ra1;
  logic [DATA_WIDTH-1:0] cur_v, hold_v;
  logic [DATA_WIDTH-1:0] a_v, b_v, pick_v, wd;
  logic                  has_r, pick_b, we;

  function automatic logic above(input logic [DATA_WIDTH-1:0] a,
                                 input logic [DATA_WIDTH-1:0] b,
                                 input logic is_min);
    above = is_min ? (a < b) : (a > b);
  endfunction

  assign lo_eff    = in_beat.start_new ? '0 : lo_size;
  assign up_eff    = in_beat.start_new ? '0 : up_size;
  assign total_eff = CW'(lo_eff) + CW'(up_eff);
  assign total     = CW'(lo_size) + CW'(up_size);
  assign drop_next = (total_eff >= CW'(MAX_COUNT)) ||
                     ((lo_eff != up_eff) ? (up_eff >= SW'(UP_D)) : (lo_eff >= SW'(LO_D)));

  assign cur_size = sel_up ? up_size : lo_size;
  assign parent   = (pos - PW'(1)) >> 1;
  assign left     = {pos[PW-2:0], 1'b1};
  assign right    = left + PW'(1);
  assign a_v      = sel_up ? up_rd0 : lo_rd0;
  assign b_v      = sel_up ? up_rd1 : lo_rd1;
  assign has_r    = right < PW'(cur_size);
  assign pick_b   = has_r && above(b_v, a_v, sel_up);
  assign pick_v   = pick_b ? b_v : a_v;
  assign pick_a   = pick_b ? right : left;

  // Two read addresses, shared by both heaps; the tops are read by default.
  always_comb begin
    ra0 = '0;
    ra1 = '0;
    if (cmd.up_read) begin
      ra0 = parent;
    end else if (cmd.dn_read) begin
      ra0 = left;
      ra1 = right;
    end
  end

  // At most one write per cycle, always at the hole of the heap under work.
  always_comb begin
    we = 1'b0;
    wd = cur_v;
    if (cmd.up_place || cmd.dn_place) begin
      we = 1'b1;
    end else if (cmd.up_move) begin
      we = 1'b1;
      wd = a_v;
    end else if (cmd.dn_move) begin
      we = 1'b1;
      wd = pick_v;
    end
  end

  always_ff @(posedge clk) begin
    if (we && !sel_up) lo_mem[pos[LIW-1:0]] <= wd;
    if (we && sel_up)  up_mem[pos[UIW-1:0]] <= wd;
    lo_rd0 <= lo_mem[ra0[LIW-1:0]];
    lo_rd1 <= lo_mem[ra1[LIW-1:0]];
    up_rd0 <= up_mem[ra0[UIW-1:0]];
    up_rd1 <= up_mem[ra1[UIW-1:0]];
  end

  assign stat.drop      = drop;
  assign stat.at_root   = (pos == '0);
  assign stat.up_above  = above(cur_v, a_v, sel_up);
  assign stat.need_swap = (lo_size != '0) && (up_size != '0) && (lo_rd0 > up_rd0);
  assign stat.leaf      = left >= PW'(cur_size);
  assign stat.dn_above  = above(pick_v, cur_v, sel_up);
  assign stat.on_upper  = sel_up;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_size <= '0;
      up_size <= '0;
    end else if (cmd.accept) begin
      lo_size <= lo_eff;
      up_size <= up_eff;
    end else if (cmd.up_place) begin
      if (sel_up) up_size <= up_size + SW'(1);
      else        lo_size <= lo_size + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_v  <= DATA_WIDTH'(in_beat.sample);
      sel_up <= (lo_eff != up_eff);
      drop   <= drop_next;
      pos    <= (lo_eff != up_eff) ? PW'(up_eff) : PW'(lo_eff);
    end
    if (cmd.up_move) pos <= parent;
    // The lower heap takes the upper top and the upper heap the lower top.
    if (cmd.top_swap) begin
      sel_up <= 1'b0;
      pos    <= '0;
      cur_v  <= up_rd0;
      hold_v <= lo_rd0;
    end
    if (cmd.dn_move) pos <= pick_a;
    if (cmd.dn_switch) begin
      sel_up <= 1'b1;
      pos    <= '0;
      cur_v  <= hold_v;
    end
    if (cmd.finish) begin
      out_beat.median    <= (lo_size != '0) ? rmth_pkg::MEDIAN_W'(lo_rd0) : '0;
      out_beat.count     <= rmth_pkg::COUNT_W'(total);
      out_beat.full_drop <= drop;
    end
  end
endmodule

// ----- rtl/running_median_two_heaps.sv -----
// Top level of the running median block built from two heaps.
`timescale 1ns / 1ps
// Usage: offer one sample per input beat on in_valid/in_ready with the
// payload in_data (sample and start_new). The block returns exactly one
// result beat per input beat on out_valid/out_ready carrying the lower
// median, the number of samples held and a flag that tells whether the
// sample was dropped because the store was full. Setting start_new empties
// both heaps before the sample is inserted.
// One item is in work at a time. Each heap memory gives registered read data,
// so each level the sift-up climbs takes a read state and a compare state
// (ST_UP, ST_UP_CMP), and so does each level a sift-down descends (ST_DN_RD,
// ST_DN_CMP). A dropped sample skips the sift-up and the top exchange; an
// insert then reads and compares the tops (ST_TOP_RD, ST_TOP_CMP) and, when
// they are out of order, sifts down the lower heap and then the upper heap.
// in_ready rises again together with out_valid, when the result is loaded.
// Reset empties both heaps and clears the controller state; heap contents are
// left as they are and are never read before they are written.
// When the receiver stalls, the finished result waits in the output
// register and the next item may still be taken and worked on; its result
// is held back until the previous beat has been taken.
module running_median_two_heaps #(
  parameter int MAX_COUNT  = rmth_pkg::MAX_COUNT_DEF,
  parameter int DATA_WIDTH = rmth_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rmth_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rmth_pkg::out_beat_t out_data
);
  rmth_pkg::cmd_t  cmd;
  rmth_pkg::stat_t stat;

  // Sequencer for insertion, top exchange and both sift-down passes.
  rmth_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Heap memories, sizes and compare logic.
  rmth_dp #(
    .MAX_COUNT  (MAX_COUNT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (in_data),
    .out_beat (out_data),
    .cmd      (cmd),
    .stat     (stat)
  );
endmodule
